[rtl/cwps_pkg.sv]
// Package: types, constants and state codes for the centered window path smoother.
package cwps_pkg;

    localparam int MAX_RADIUS_DEF    = 15;
    // all axes share one Q format, so the fraction width changes no arithmetic
    localparam int FRACTION_BITS_DEF = 16;
    localparam int POS_W             = 32;
    localparam int STAMP_W           = 64;
    localparam int RAD_W             = 4;
    localparam int SEEN_W            = 16;

    typedef struct packed {
        logic signed [STAMP_W-1:0] time_stamp;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_angle;
        logic                      last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [STAMP_W-1:0] out_time_stamp;
        logic signed [POS_W-1:0]   cum_x;
        logic signed [POS_W-1:0]   avg_x;
        logic signed [POS_W-1:0]   norm_x;
        logic signed [POS_W-1:0]   cum_y;
        logic signed [POS_W-1:0]   avg_y;
        logic signed [POS_W-1:0]   norm_y;
        logic signed [POS_W-1:0]   cum_angle;
        logic signed [POS_W-1:0]   avg_angle;
        logic signed [POS_W-1:0]   norm_angle;
        logic                      last_result;
    } t_out_item;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RD,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

[rtl/centered_window_path_smoother.sv]
// Top level: centered moving-average smoother for camera path samples.
//
// Channels: input samples on i_in_valid/o_in_ready with payload i_in (t_in_item),
// results on o_out_valid/i_out_ready with payload o_out (t_out_item), and the
// smoothing radius on i_cfg_valid/o_cfg_ready/i_cfg_data (taken only in idle
// while no sample is offered).
// A sample is stored in a history ring of 2*MAX_RADIUS+2 entries. Once its right
// neighbours have arrived, the result for the sample radius places back is
// formed; a sample flagged last emits every pending result, oldest first.
// Per result, one accumulator per axis sums the window one entry a cycle (1 to
// 2*MAX_RADIUS+1 entries, after a setup step and then a drain of the read and
// accumulate registers); then one serial divider runs three times, one axis after
// another, and the result is registered. A sample with no result leaves the
// input ready on the next cycle. The input is not ready while a result is formed.
// The result register holds its transaction while the receiver stalls; the
// sequencer waits on it. Reset clears the radius, stream count and ring pointer;
// the history memory is not cleared, only entries of the current stream are read.
// A radius write restarts the stream and drops pending samples.
module centered_window_path_smoother
    import cwps_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [RAD_W-1:0] i_cfg_data
);
    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int PTR_W = $clog2(RING);
    localparam int DST_W = $clog2(RING);
    localparam int CNT_W = $clog2(2 * MAX_RADIUS + 2);
    localparam int SUM_W = POS_W + CNT_W + 1;
    localparam int RMX_W = $clog2(MAX_RADIUS + 1);

    t_state r_state, n_state;

    logic [STAMP_W-1:0] mem_stamp [RING];
    logic [POS_W-1:0]   mem_x     [RING];
    logic [POS_W-1:0]   mem_y     [RING];
    logic [POS_W-1:0]   mem_a     [RING];

    logic [RAD_W-1:0]  r_rad;
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic [SEEN_W-1:0] r_n;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_cur, n_cur;
    logic              r_last, n_last;
    logic [DST_W-1:0]  r_d, n_d;
    logic [DST_W-1:0]  r_right, n_right;
    logic [DST_W-1:0]  r_left, n_left;
    logic [DST_W-1:0]  r_e, n_e;
    logic [1:0]        r_axis, n_axis;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_rd_go, n_rd_go;
    logic              r_acc_en;
    logic              r_acc_tail;

    logic signed [SUM_W-1:0] r_sx, r_sy, r_sa;
    logic [POS_W-1:0]   r_rx, r_ry, r_ra;
    logic [STAMP_W-1:0] r_rstamp;
    logic signed [POS_W-1:0] r_avg_x, r_avg_y, r_avg_a;
    logic               r_ov;
    t_out_item          r_out;

    logic [RMX_W-1:0]   w_r;
    logic               w_in_acc, w_cfg_acc;
    logic [SEEN_W-1:0]  w_seen_inc;
    logic [PTR_W-1:0]   w_slot;
    logic               w_div_start, w_div_done;
    logic signed [SUM_W-1:0] w_dvd, w_quo;
    logic               w_acc_clr;
    logic               w_emit;

    // radius clamped to the build limit
    assign w_r = (r_rad > RAD_W'(MAX_RADIUS)) ? RMX_W'(MAX_RADIUS) : RMX_W'(r_rad);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_in_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_seen_inc  = (r_seen == '1) ? r_seen : r_seen + 1'b1;

    // ring slot for distance r_e back from the newest sample
    always_comb begin
        if ({1'b0, r_e} > {1'b0, r_cur})
            w_slot = PTR_W'(RING) + r_cur - PTR_W'(r_e);
        else
            w_slot = r_cur - PTR_W'(r_e);
    end

    // history write and single read port
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            mem_stamp[r_wp] <= i_in.time_stamp;
            mem_x[r_wp]     <= i_in.pos_x;
            mem_y[r_wp]     <= i_in.pos_y;
            mem_a[r_wp]     <= i_in.pos_angle;
        end
        r_rx      <= mem_x[w_slot];
        r_ry      <= mem_y[w_slot];
        r_ra      <= mem_a[w_slot];
        r_rstamp  <= mem_stamp[w_slot];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_seen  = r_seen;
        n_wp    = r_wp;
        n_cur   = r_cur;
        n_last  = r_last;
        n_d     = r_d;
        n_right = r_right;
        n_e     = r_e;
        n_axis  = r_axis;
        n_rd_go = 1'b0;
        w_div_start = 1'b0;
        w_acc_clr   = 1'b0;
        w_emit      = 1'b0;
        w_dvd       = r_sx;
        case (r_axis)
            2'd1:    w_dvd = r_sy;
            2'd2:    w_dvd = r_sa;
            default: w_dvd = r_sx;
        endcase
        case (r_state)
            ST_IDLE: begin
                if (w_cfg_acc) begin
                    n_seen = '0;
                    n_wp   = '0;
                end else if (w_in_acc) begin
                    n_seen = w_seen_inc;
                    n_cur  = r_wp;
                    n_last = i_in.last_sample;
                    if (i_in.last_sample) begin
                        // flush: start with the oldest pending sample
                        if ((w_seen_inc - 1'b1) < SEEN_W'(w_r))
                            n_d = DST_W'(w_seen_inc - 1'b1);
                        else
                            n_d = DST_W'(w_r);
                        n_right = n_d;
                        n_state = ST_SETUP;
                        n_seen  = '0;
                        n_wp    = '0;
                    end else begin
                        n_wp = (r_wp == PTR_W'(RING - 1)) ? '0 : r_wp + 1'b1;
                        n_d     = DST_W'(w_r);
                        n_right = DST_W'(w_r);
                        if ((w_seen_inc - 1'b1) >= SEEN_W'(w_r))
                            n_state = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                // left extent: min(n-1-d, r); n kept in r_n
                w_acc_clr = 1'b1;
                n_e       = r_d - r_right;
                n_state   = ST_RD;
            end
            ST_RD: begin
                n_rd_go = 1'b1;
                if (r_e == r_d + r_left)
                    n_state = ST_ACC;
                else
                    n_e = r_e + 1'b1;
            end
            ST_ACC: begin
                // wait for the last read to land in the sums
                if (!r_acc_en && !r_acc_tail) begin
                    n_e         = r_d;
                    n_axis      = 2'd0;
                    w_div_start = 1'b1;
                    w_dvd       = r_sx;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    if (r_axis == 2'd2) begin
                        n_state = ST_OUT;
                    end else begin
                        n_axis      = r_axis + 1'b1;
                        w_div_start = 1'b1;
                        case (r_axis + 1'b1)
                            2'd1:    w_dvd = r_sy;
                            default: w_dvd = r_sa;
                        endcase
                    end
                end
            end
            ST_OUT: begin
                if (!r_ov || i_out_ready) begin
                    w_emit = 1'b1;
                    if (r_d == '0 || !r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_d     = r_d - 1'b1;
                        n_right = r_d - 1'b1;
                        n_state = ST_SETUP;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // left extent and window count for the current result
    always_ff @(posedge i_clk) begin
        if (w_in_acc)
            r_n <= w_seen_inc;
    end
    always_comb begin
        if ((r_n - 1'b1 - SEEN_W'(r_d)) < SEEN_W'(w_r))
            n_left = DST_W'(r_n - 1'b1 - SEEN_W'(r_d));
        else
            n_left = DST_W'(w_r);
        n_cnt = CNT_W'(n_left) + CNT_W'(r_right) + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rad   <= '0;
            r_seen  <= '0;
            r_wp    <= '0;
            r_acc_en   <= 1'b0;
            r_acc_tail <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc)
                r_rad <= i_cfg_data;
            r_seen  <= n_seen;
            r_wp    <= n_wp;
            r_acc_en   <= n_rd_go;
            r_acc_tail <= r_acc_en;
            if (w_emit)
                r_ov <= 1'b1;
            else if (i_out_ready)
                r_ov <= 1'b0;
        end
        r_cur   <= n_cur;
        r_last  <= n_last;
        r_d     <= n_d;
        r_right <= n_right;
        r_e     <= n_e;
        r_axis  <= n_axis;
        if (r_state == ST_SETUP) begin
            r_left <= n_left;
            r_cnt  <= n_cnt;
        end
    end

    // per-axis accumulators, one window entry a cycle
    always_ff @(posedge i_clk) begin
        if (w_acc_clr) begin
            r_sx <= '0;
            r_sy <= '0;
            r_sa <= '0;
        end else if (r_acc_en) begin
            r_sx <= r_sx + SUM_W'($signed(r_rx));
            r_sy <= r_sy + SUM_W'($signed(r_ry));
            r_sa <= r_sa + SUM_W'($signed(r_ra));
        end
    end

    cwps_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // capture quotients; e = d so the read port now shows the center sample
    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            case (r_axis)
                2'd0:    r_avg_x <= POS_W'(w_quo);
                2'd1:    r_avg_y <= POS_W'(w_quo);
                default: r_avg_a <= POS_W'(w_quo);
            endcase
        end
    end

    function automatic logic [POS_W-1:0] f_sat(input logic signed [POS_W-1:0] a,
                                               input logic [POS_W-1:0] v);
        logic signed [POS_W:0] s;
        s = {a[POS_W-1], a} - {v[POS_W-1], v};
        if (s[POS_W] != s[POS_W-1])
            f_sat = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        else
            f_sat = s[POS_W-1:0];
    endfunction

    // output register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.out_time_stamp <= r_rstamp;
            r_out.cum_x      <= r_rx;
            r_out.avg_x      <= r_avg_x;
            r_out.norm_x     <= f_sat(r_avg_x, r_rx);
            r_out.cum_y      <= r_ry;
            r_out.avg_y      <= r_avg_y;
            r_out.norm_y     <= f_sat(r_avg_y, r_ry);
            r_out.cum_angle  <= r_ra;
            r_out.avg_angle  <= r_avg_a;
            r_out.norm_angle <= f_sat(r_avg_a, r_ra);
            r_out.last_result <= r_last && (r_d == '0);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule

[rtl/cwps_div.sv]
// Serial restoring divider: signed dividend by small unsigned count, truncating.
module cwps_div
    import cwps_pkg::*;
#(
    parameter int DVD_W = 40,
    parameter int DVS_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W:0]   r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_neg, n_neg;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_sub;

    // One quotient bit per cycle
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
        w_sub   = w_trial - {1'b0, i_divisor};
        if (i_start) begin
            n_neg  = i_dividend[DVD_W-1];
            n_quo  = i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
            n_rem  = '0;
            n_cnt  = CNT_W'(DVD_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem = w_sub;
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

[rtl/cwps_checker.sv]
// Port-level checker for the path smoother, bound to the top level.
module cwps_port_checker
    import cwps_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out,
    input logic      o_cfg_ready
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed under stall");

    // config is taken only when the input side is idle too
    a_cfg_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> o_in_ready)
        else $error("cfg ready while input not ready");

    // idle with no sample offered accepts config
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && !i_in_valid |-> o_cfg_ready)
        else $error("cfg not ready while idle");

    // no new result while idle without a sample
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && !i_in_valid && !o_out_valid |=> !o_out_valid)
        else $error("result appeared without a sample");

endmodule

bind centered_window_path_smoother cwps_port_checker u_cwps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .o_cfg_ready (o_cfg_ready)
);
